// ===== rtl/rgbbb_pkg.sv =====
`timescale 1ns / 1ps

package rgbbb_pkg;

    localparam int CH_BITS  = 8;
    localparam int PIX_BITS = 32;
    localparam int POS_BITS = 5;
    localparam int CFG_BITS = 32;
    localparam int IDX_BITS = 3;
    localparam int NUM_CH   = 3;

    typedef logic [CH_BITS-1:0]  t_ch;
    typedef logic [PIX_BITS-1:0] t_pix;
    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [1:0]          t_func;

    localparam t_ch CH_MAX = {CH_BITS{1'b1}};

    localparam t_func FUNC_BRIGHT = 2'd0;
    localparam t_func FUNC_FILL   = 2'd1;
    localparam t_func FUNC_BLEND  = 2'd2;
    localparam t_func FUNC_PASTE  = 2'd3;

    localparam logic [IDX_BITS-1:0] CFG_RED_POS   = 3'd0;
    localparam logic [IDX_BITS-1:0] CFG_GREEN_POS = 3'd1;
    localparam logic [IDX_BITS-1:0] CFG_BLUE_POS  = 3'd2;
    localparam logic [IDX_BITS-1:0] CFG_LEVEL     = 3'd3;
    localparam logic [IDX_BITS-1:0] CFG_FILL      = 3'd4;
    localparam logic [IDX_BITS-1:0] CFG_SPRITE    = 3'd5;

    localparam t_pos RST_RED_POS   = 5'd16;
    localparam t_pos RST_GREEN_POS = 5'd8;
    localparam t_pos RST_BLUE_POS  = 5'd0;
    localparam t_ch  RST_LEVEL     = 8'd128;

    // Brightness map: level below mid darkens by 2*(127-b), else brightens by 2*(b-128)
    function automatic t_ch bright(input t_ch b, input t_ch c);
        t_ch            dec;
        logic [CH_BITS:0] sum;
        dec = {7'(7'd127 - b[CH_BITS-2:0]), 1'b0};
        sum = {1'b0, c} + {1'b0, b[CH_BITS-2:0], 1'b0};
        if (!b[CH_BITS-1]) begin
            return (c > dec) ? t_ch'(c - dec) : '0;
        end else begin
            return sum[CH_BITS] ? CH_MAX : sum[CH_BITS-1:0];
        end
    endfunction

    function automatic t_ch blend(input t_ch d, input t_ch s, input t_ch t);
        logic [2*CH_BITS-1:0] p;
        p = (2*CH_BITS)'(d) * (2*CH_BITS)'(CH_MAX - t) + (2*CH_BITS)'(s) * (2*CH_BITS)'(t);
        return p[2*CH_BITS-1:CH_BITS];
    endfunction

    function automatic t_ch get_ch(input t_pix pix, input t_pos pos);
        t_pix sh;
        sh = pix >> pos;
        return sh[CH_BITS-1:0];
    endfunction

    function automatic t_pix put_ch(input t_ch val, input t_pos pos);
        return t_pix'(val) << pos;
    endfunction

endpackage

// ===== rtl/rgb_pixel_brightness_blend_unit.sv =====
`timescale 1ns / 1ps

// Per-pixel color unit for 32-bit pixels with three 8-bit channels at
// programmable bit positions. i_func selects brightness (0), blend toward the
// fill color (1), blend of source over destination (2) or brightness paste (3).
// One word is accepted per cycle while o_stall is low; each word is held in the input
// register, then in the result register, with a full per-pixel compute between them.
// Bits outside the channels are cleared in computed pixels; when o_write_enable is low,
// o_out_pixel is the destination unchanged. Configuration is to be written by the user
// through i_cfg_we/i_cfg_index/i_cfg_data only while idle; the block does not enforce this.
module rgb_pixel_brightness_blend_unit
    import rgbbb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_func               i_func,
    input  t_pix                i_src_pixel,
    input  t_pix                i_dst_pixel,
    output logic                o_valid,
    input  logic                i_stall,
    output t_pix                o_out_pixel,
    output logic                o_write_enable
);

    t_pos  r_red_pos, r_green_pos, r_blue_pos;
    t_ch   r_level;
    t_pix  r_fill;
    logic  r_sprite;

    logic  r_s1_valid;
    t_func r_s1_func;
    t_pix  r_s1_src;
    t_pix  r_s1_dst;

    logic  r_out_valid;
    t_pix  r_out_pixel;
    logic  r_out_we;

    logic  in_accept;
    logic  s1_adv;
    t_pos  pos [NUM_CH];
    t_pix  s_pix;
    logic  black;
    t_pix  n_out_pixel;
    logic  n_out_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_pos   <= RST_RED_POS;
            r_green_pos <= RST_GREEN_POS;
            r_blue_pos  <= RST_BLUE_POS;
            r_level     <= RST_LEVEL;
            r_fill      <= '0;
            r_sprite    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RED_POS:   r_red_pos   <= i_cfg_data[POS_BITS-1:0];
                CFG_GREEN_POS: r_green_pos <= i_cfg_data[POS_BITS-1:0];
                CFG_BLUE_POS:  r_blue_pos  <= i_cfg_data[POS_BITS-1:0];
                CFG_LEVEL:     r_level     <= i_cfg_data[CH_BITS-1:0];
                CFG_FILL:      r_fill      <= i_cfg_data[PIX_BITS-1:0];
                CFG_SPRITE:    r_sprite    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign s1_adv    = !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !s1_adv;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func <= i_func;
            r_s1_src  <= i_src_pixel;
            r_s1_dst  <= i_dst_pixel;
        end
    end

    always_comb begin
        pos[0] = r_red_pos;
        pos[1] = r_green_pos;
        pos[2] = r_blue_pos;
        s_pix  = (r_s1_func == FUNC_FILL) ? r_fill : r_s1_src;
        black  = (get_ch(s_pix, pos[0]) == '0) && (get_ch(s_pix, pos[1]) == '0) &&
                 (get_ch(s_pix, pos[2]) == '0);
        n_out_pixel = '0;
        n_out_we    = 1'b1;
        case (r_s1_func)
            FUNC_BRIGHT: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    n_out_pixel |= put_ch(bright(r_level, get_ch(r_s1_dst, pos[i])), pos[i]);
                end
            end
            FUNC_PASTE: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    n_out_pixel |= put_ch(bright(bright(r_level, get_ch(r_s1_src, pos[i])),
                                                 get_ch(r_s1_dst, pos[i])), pos[i]);
                end
            end
            default: begin
                if (r_level == '0 || (r_s1_func == FUNC_BLEND && r_sprite && black)) begin
                    n_out_pixel = r_s1_dst;
                    n_out_we    = 1'b0;
                end else if (r_level == CH_MAX) begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        n_out_pixel |= put_ch(get_ch(s_pix, pos[i]), pos[i]);
                    end
                end else begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        n_out_pixel |= put_ch(blend(get_ch(r_s1_dst, pos[i]),
                                                    get_ch(s_pix, pos[i]), r_level), pos[i]);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_pixel <= n_out_pixel;
            r_out_we    <= n_out_we;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_pixel    = r_out_pixel;
    assign o_write_enable = r_out_we;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rgbbb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 14;
    localparam int PHASE_WORDS = 100;

    typedef struct {
        t_func func;
        t_pix  src;
        t_pix  dst;
    } pixel_word_t;

    typedef struct {
        t_pix pixel;
        logic write_en;
    } pixel_result_t;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_BITS-1:0] i_cfg_data  = '0;
    logic                i_valid     = 1'b0;
    logic                o_stall;
    t_func               i_func      = FUNC_BRIGHT;
    t_pix                i_src_pixel = '0;
    t_pix                i_dst_pixel = '0;
    logic                o_valid;
    logic                i_stall     = 1'b0;
    t_pix                o_out_pixel;
    logic                o_write_enable;

    rgb_pixel_brightness_blend_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_src_pixel    (i_src_pixel),
        .i_dst_pixel    (i_dst_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_pixel    (o_out_pixel),
        .o_write_enable (o_write_enable)
    );

    // shadow of the register file
    t_pos red_at    = RST_RED_POS;
    t_pos green_at  = RST_GREEN_POS;
    t_pos blue_at   = RST_BLUE_POS;
    t_ch  amount    = RST_LEVEL;
    t_pix fill      = '0;
    logic sprite_on = 1'b0;

    pixel_word_t   pixels_to_send[$];
    pixel_result_t results_due[$];
    pixel_word_t   next_word;
    pixel_result_t want;

    int   mismatches  = 0;
    int   cycle_count = 0;
    int   send_wait   = 0;
    int   hold_left   = 0;
    logic word_taken  = 1'b0;
    logic calm        = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_ch level_map(input t_ch b, input t_ch c);
        int unsigned v;
        if (b < 128) begin
            v = 2 * (127 - b);
            return (c > v) ? t_ch'(c - v) : '0;
        end
        v = c + 2 * (b - 128);
        return (v > 255) ? 8'hFF : t_ch'(v);
    endfunction

    function automatic t_ch mix(input t_ch d, input t_ch s, input t_ch t);
        int unsigned p;
        p = d * (255 - t) + s * t;
        return t_ch'(p >> 8);
    endfunction

    function automatic t_ch pick(input t_pix pix, input t_pos pos);
        return t_ch'(pix >> pos);
    endfunction

    function automatic t_pix place(input t_ch val, input t_pos pos);
        return t_pix'(val) << pos;
    endfunction

    function automatic pixel_result_t compute_pixel(input t_func op, input t_pix src,
                                                    input t_pix dst);
        t_pos          at[3];
        t_pix          origin;
        t_ch           lvl;
        logic          dark;
        pixel_result_t r;
        at[0] = red_at;
        at[1] = green_at;
        at[2] = blue_at;
        r.pixel = '0;
        r.write_en = 1'b1;
        case (op)
            FUNC_BRIGHT: begin
                for (int k = 0; k < NUM_CH; k++)
                    r.pixel |= place(level_map(amount, pick(dst, at[k])), at[k]);
            end
            FUNC_PASTE: begin
                for (int k = 0; k < NUM_CH; k++) begin
                    lvl = level_map(amount, pick(src, at[k]));
                    r.pixel |= place(level_map(lvl, pick(dst, at[k])), at[k]);
                end
            end
            default: begin
                origin = (op == FUNC_FILL) ? fill : src;
                dark = pick(origin, at[0]) == 0 && pick(origin, at[1]) == 0 &&
                       pick(origin, at[2]) == 0;
                if (amount == 0 || (op == FUNC_BLEND && sprite_on && dark)) begin
                    r.pixel = dst;
                    r.write_en = 1'b0;
                end else if (amount == 8'hFF) begin
                    for (int k = 0; k < NUM_CH; k++)
                        r.pixel |= place(pick(origin, at[k]), at[k]);
                end else begin
                    for (int k = 0; k < NUM_CH; k++)
                        r.pixel |= place(mix(pick(dst, at[k]), pick(origin, at[k]), amount),
                                         at[k]);
                end
            end
        endcase
        return r;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || word_taken)) begin
            word_taken = 1'b0;
            if (send_wait > 0) begin
                send_wait--;
                i_valid <= 1'b0;
            end else if (pixels_to_send.size() != 0) begin
                next_word = pixels_to_send.pop_front();
                i_func <= next_word.func;
                i_src_pixel <= next_word.src;
                i_dst_pixel <= next_word.dst;
                i_valid <= 1'b1;
                send_wait = draw_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!o_valid && !calm) begin
                i_stall <= 1'($urandom_range(0, 1));
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                results_due.push_back(compute_pixel(i_func, i_src_pixel, i_dst_pixel));
                word_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                hold_left = draw_gap();
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, actual %h we %b",
                             $time, o_out_pixel, o_write_enable);
                end else begin
                    want = results_due.pop_front();
                    if (o_out_pixel !== want.pixel) begin
                        mismatches++;
                        $display("%0t: out_pixel expected %h actual %h",
                                 $time, want.pixel, o_out_pixel);
                    end
                    if (o_write_enable !== want.write_en) begin
                        mismatches++;
                        $display("%0t: write_enable expected %b actual %b",
                                 $time, want.write_en, o_write_enable);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic set_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_RED_POS:   red_at = data[POS_BITS-1:0];
            CFG_GREEN_POS: green_at = data[POS_BITS-1:0];
            CFG_BLUE_POS:  blue_at = data[POS_BITS-1:0];
            CFG_LEVEL:     amount = data[CH_BITS-1:0];
            CFG_FILL:      fill = data;
            CFG_SPRITE:    sprite_on = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(input t_func op, input t_pix src, input t_pix dst);
        pixel_word_t w;
        w.func = op;
        w.src = src;
        w.dst = dst;
        pixels_to_send.push_back(w);
    endtask

    task automatic settle();
        while (pixels_to_send.size() != 0 || i_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_random_words(input int n);
        t_pix  s;
        t_pix  d;
        t_pix  keymask;
        t_func op;
        keymask = place(8'hFF, red_at) | place(8'hFF, green_at) | place(8'hFF, blue_at);
        for (int k = 0; k < n; k++) begin
            s = $urandom;
            d = $urandom;
            op = t_func'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0: begin
                    s = s & ~keymask;
                    op = FUNC_BLEND;
                end
                1: s = '0;
                2: d = '1;
                3: begin
                    s = '1;
                    d = '0;
                end
                default: ;
            endcase
            send(op, s, d);
        end
    endtask

    function automatic logic [CFG_BITS-1:0] with_junk(input logic [CFG_BITS-1:0] v,
                                                      input logic [CFG_BITS-1:0] keep);
        return (32'($urandom) & ~keep) | v;
    endfunction

    function automatic t_pos draw_pos(input int style, input t_pos usual);
        case (style)
            2:       return t_pos'($urandom_range(0, 24));
            3:       return t_pos'($urandom_range(0, 31));
            default: return usual;
        endcase
    endfunction

    int style;
    int pick_level;
    t_ch new_level;

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration
        send(FUNC_BRIGHT, 32'h0000_0000, 32'hFFFF_FFFF);
        send(FUNC_BRIGHT, 32'hFFFF_FFFF, 32'h0000_0000);
        send(FUNC_FILL,   32'h0000_0000, 32'h1234_5678);
        send(FUNC_BLEND,  32'hFFFF_FFFF, 32'h0000_0000);
        send(FUNC_PASTE,  32'hFFFF_FFFF, 32'h8080_8080);
        send(FUNC_PASTE,  32'h0000_0000, 32'hFFFF_FFFF);
        settle();

        // level zero: no change for the blends, full darkening
        set_reg(CFG_LEVEL, 32'd0);
        set_reg(CFG_FILL, 32'hA1B2_C3D4);
        send(FUNC_BRIGHT, 32'h0000_0000, 32'hFFFF_FFFF);
        send(FUNC_FILL,   32'h0000_0000, 32'hDEAD_BEEF);
        send(FUNC_BLEND,  32'hFFFF_FFFF, 32'hDEAD_BEEF);
        send(FUNC_PASTE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        settle();

        // level full: copy and fill
        set_reg(CFG_LEVEL, 32'd255);
        set_reg(CFG_FILL, 32'hFFFF_FFFF);
        send(FUNC_BRIGHT, 32'h0000_0000, 32'h0102_0304);
        send(FUNC_FILL,   32'h0000_0000, 32'h0000_0000);
        send(FUNC_BLEND,  32'h1122_3344, 32'hFFFF_FFFF);
        send(FUNC_PASTE,  32'h0000_0000, 32'h00FF_7F80);
        settle();

        // black key, sprite mode ignored by fill
        set_reg(CFG_LEVEL, 32'd127);
        set_reg(CFG_SPRITE, 32'd1);
        set_reg(CFG_FILL, 32'd0);
        send(FUNC_BLEND,  32'hFF00_0000, 32'h5555_5555);
        send(FUNC_BLEND,  32'h0000_0001, 32'h5555_5555);
        send(FUNC_BLEND,  32'h00FF_0000, 32'hAAAA_AAAA);
        send(FUNC_FILL,   32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send(FUNC_BRIGHT, 32'h0000_0000, 32'h8080_8080);
        settle();

        // positions past the top and overlapping
        set_reg(CFG_RED_POS, 32'd31);
        set_reg(CFG_GREEN_POS, 32'd24);
        set_reg(CFG_BLUE_POS, 32'd20);
        set_reg(CFG_LEVEL, 32'd128);
        set_reg(CFG_SPRITE, 32'd0);
        send(FUNC_BRIGHT, 32'h0000_0000, 32'hFFFF_FFFF);
        send(FUNC_PASTE,  32'h9C3E_71A5, 32'h5AC3_0F96);
        send(FUNC_BLEND,  32'hFFFF_FFFF, 32'h0000_0000);
        settle();

        set_reg(CFG_RED_POS, 32'd0);
        set_reg(CFG_GREEN_POS, 32'd0);
        set_reg(CFG_BLUE_POS, 32'd0);
        set_reg(CFG_LEVEL, 32'd200);
        set_reg(CFG_FILL, 32'h0000_00C3);
        send(FUNC_BRIGHT, 32'h0000_0000, 32'h0000_00F0);
        send(FUNC_FILL,   32'h0000_0000, 32'h1234_5678);
        send(FUNC_BLEND,  32'h8765_4321, 32'h1234_5678);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            calm = (phase % 4 == 0);
            style = $urandom_range(0, 3);
            set_reg(CFG_RED_POS, with_junk(32'(draw_pos(style, RST_RED_POS)), 32'h1F));
            set_reg(CFG_GREEN_POS, with_junk(32'(draw_pos(style, RST_GREEN_POS)), 32'h1F));
            set_reg(CFG_BLUE_POS, with_junk(32'(draw_pos(style, RST_BLUE_POS)), 32'h1F));
            pick_level = $urandom_range(0, 5);
            case (pick_level)
                0:       new_level = 8'd0;
                1:       new_level = 8'd255;
                2:       new_level = t_ch'($urandom_range(126, 129));
                default: new_level = t_ch'($urandom_range(0, 255));
            endcase
            set_reg(CFG_LEVEL, with_junk(32'(new_level), 32'hFF));
            case ($urandom_range(0, 3))
                0:       set_reg(CFG_FILL, 32'h0000_0000);
                1:       set_reg(CFG_FILL, 32'hFFFF_FFFF);
                default: set_reg(CFG_FILL, $urandom);
            endcase
            set_reg(CFG_SPRITE, with_junk(32'($urandom_range(0, 1)), 32'h1));
            if (phase % 2 == 1) begin
                // hold the sender until the pipeline is empty
                send_random_words(PHASE_WORDS / 2);
                settle();
                send_random_words(PHASE_WORDS - PHASE_WORDS / 2);
            end else begin
                send_random_words(PHASE_WORDS);
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
